[hdl/first_fit_block_allocator_defines.svh]
// ----------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Shared macros for the concurrent checks of the allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication checked on every rising edge outside reset.
`define FFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");
// Next-cycle implication checked on every rising edge outside reset.
`define FFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");
`else
`define FFA_ASSERT_IMP(lbl, ante, cons)
`define FFA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hdl/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Sizes, codes and the types passed between the controller and the cells.
// ----------------------------------------------------------------------------
`default_nettype none
package ffa_pkg;
  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int OFFSET_BITS  = 24;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [OFFSET_BITS-1:0] HEAP_RESET = OFFSET_BITS'(1048576);
  localparam logic [OFFSET_BITS-1:0] HDR = OFFSET_BITS'(HEADER_BYTES);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_UNKN  = 2'd2;
  localparam logic [1:0] ST_NULL  = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE, OP_CLEAR, OP_SET, OP_INSERT, OP_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic                   valid;
    logic                   used;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] pay;
  } entry_t;

  typedef struct packed {
    cell_op_t               op;
    logic [IW-1:0]          idx;
    logic                   free_mode;
    logic                   used_val;
    logic [OFFSET_BITS-1:0] size;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] new_start;
    logic [OFFSET_BITS-1:0] new_pay;
    logic [OFFSET_BITS-1:0] heap;
  } cell_ctl_t;

  typedef struct packed {
    logic                   sel;
    logic [IW-1:0]          idx;
    logic                   used;
    logic                   prev_free;
    logic                   next_free;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] pay;
  } cell_rep_t;
endpackage
`default_nettype wire

[hdl/first_fit_block_allocator.sv]
// An allocate or a failed free goes from the search state to the act state and then to
// the result; a successful free marks the block, then merges with next and with previous.
// A new command is taken only once the result of the last one has been transferred.
// The search is one pass over the row of cells; splits and merges are one shift each.
// Reset (synchronous, rst_n low) gives one free block over a 1048576-byte heap.
// A heap size write rebuilds the table.
// ----------------------------------------------------------------------------
// First-fit block allocator
// Address-ordered block table kept in a row of cells with first-fit search,
// splitting on allocate and coalescing on free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_block_allocator_defines.svh"
module first_fit_block_allocator
  import ffa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [OFFSET_BITS-1:0] cfg_wr_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_command,
  input  wire logic [OFFSET_BITS-1:0] in_request_size,
  input  wire logic [OFFSET_BITS-1:0] in_payload_offset,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [OFFSET_BITS-1:0]      out_result_offset,
  output logic [1:0]                  out_status
);
  // The controller walks each command through a short sequence; the cells
  // do the search in parallel and the shifts by handing entries along.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_ACT    = 6'b000100,
    S_MNEXT  = 6'b001000,
    S_MPREV  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic cmd_r;
  logic [OFFSET_BITS-1:0] size_r, off_r;
  cell_rep_t found_r, red;
  logic [OFFSET_BITS-1:0] res_r, res_nxt;
  logic [1:0] stat_r, stat_nxt;
  cell_ctl_t ctl;

  entry_t ents [MAX_BLOCKS];
  cell_rep_t reps [MAX_BLOCKS];
  logic [MAX_BLOCKS:0] chain;
  logic [MAX_BLOCKS-1:0] sel_vec, valid_vec;

  logic [OFFSET_BITS:0] split_lim;
  logic [OFFSET_BITS:0] res_sum;
  logic do_split;

  assign chain[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      entry_t l_ent, r_ent;
      if (g == 0) begin : g_l0
        assign l_ent = '0;
      end else begin : g_l
        assign l_ent = ents[g-1];
      end
      if (g == MAX_BLOCKS - 1) begin : g_rl
        assign r_ent = '0;
      end else begin : g_r
        assign r_ent = ents[g+1];
      end
      ffa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_id  (IW'(g)),
        .ctl      (ctl),
        .left     (l_ent),
        .right    (r_ent),
        .found_in (chain[g]),
        .found_out(chain[g+1]),
        .ent      (ents[g]),
        .rep      (reps[g])
      );
      assign sel_vec[g]   = reps[g].sel;
      assign valid_vec[g] = ents[g].valid;
    end
  endgenerate

  // At most one cell reports, so an OR over the row picks its fields.
  always_comb begin
    red = '0;
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      red = red | reps[j];
    end
  end

  // A split needs the payload to exceed the request plus a header and a
  // free table slot; otherwise the block is handed out whole.
  assign split_lim = {1'b0, size_r} + {1'b0, HDR};
  assign do_split  = ({1'b0, found_r.pay} > split_lim) && (cnt_r < CW'(MAX_BLOCKS));
  assign res_sum   = {1'b0, found_r.start} + {1'b0, HDR};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    ctl           = '0;
    ctl.op        = OP_NONE;
    ctl.free_mode = (cmd_r == CMD_FREE);
    ctl.size      = size_r;
    ctl.off       = off_r;
    ctl.idx       = found_r.idx;
    ctl.new_start = found_r.start + HDR + size_r;
    ctl.new_pay   = found_r.pay - size_r - HDR;
    ctl.heap      = cfg_wr_data;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SEARCH;
      end
      S_SEARCH: state_nxt = S_ACT;
      S_ACT: begin
        state_nxt = S_DONE;
        res_nxt   = '0;
        if (cmd_r == CMD_ALLOC) begin
          if (!found_r.sel) begin
            stat_nxt = ST_NOFIT;
          end else begin
            stat_nxt = ST_DONE;
            res_nxt  = res_sum[OFFSET_BITS-1:0];
            if (do_split) begin
              ctl.op  = OP_INSERT;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              ctl.op       = OP_SET;
              ctl.used_val = 1'b1;
            end
          end
        end else if (off_r == '0) begin
          stat_nxt = ST_NULL;
        end else if (!found_r.sel || !found_r.used) begin
          stat_nxt = ST_UNKN;
        end else begin
          stat_nxt     = ST_DONE;
          ctl.op       = OP_SET;
          ctl.used_val = 1'b0;
          state_nxt    = S_MNEXT;
        end
      end
      S_MNEXT: begin
        state_nxt = S_MPREV;
        if (found_r.next_free) begin
          ctl.op  = OP_REMOVE;
          ctl.idx = found_r.idx + 1'b1;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_MPREV: begin
        state_nxt = S_DONE;
        if (found_r.prev_free) begin
          ctl.op  = OP_REMOVE;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // Heap size writes must arrive only while idle (the block does not enforce it) and rebuild the table.
    if (cfg_wr_en) begin
      ctl.op  = OP_CLEAR;
      cnt_nxt = (cfg_wr_data >= HDR) ? CW'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= CW'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // The command registers start from a defined allocate of zero bytes so
  // that the row of cells never searches on unknown values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= CMD_ALLOC;
      size_r <= '0;
      off_r  <= '0;
    end else if (state_r == S_IDLE && in_valid) begin
      cmd_r  <= in_command;
      size_r <= in_request_size;
      off_r  <= in_payload_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SEARCH) found_r <= red;
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = (state_r == S_DONE);
  assign out_result_offset = res_r;
  assign out_status        = stat_r;

  `FFA_ASSERT_IMP(a_count_matches, 1'b1, $countones(valid_vec) == 32'(cnt_r))
  `FFA_ASSERT_IMP(a_one_select, 1'b1, $onehot0(sel_vec))
  `FFA_ASSERT_NXT(a_accept_search, in_valid && in_ready, state_r == S_SEARCH)
  `FFA_ASSERT_IMP(a_free_no_offset, out_valid && cmd_r == CMD_FREE, out_result_offset == '0)
endmodule
`default_nettype wire

[hdl/ffa_cell.sv]
// ----------------------------------------------------------------------------
// First-fit allocator cell
// Holds one table entry and trades it with its neighbors on shifts.
// ----------------------------------------------------------------------------
`default_nettype none
module ffa_cell
  import ffa_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [IW-1:0] cell_id,
  input  wire cell_ctl_t     ctl,
  input  wire entry_t        left,
  input  wire entry_t        right,
  input  wire logic          found_in,
  output logic               found_out,
  output entry_t             ent,
  output cell_rep_t          rep
);
  entry_t ent_r, ent_nxt;
  logic [OFFSET_BITS:0] off_sum;
  logic hit, sel;
  logic [IW:0] id_p1, idx_p1;

  assign off_sum = {1'b0, ent_r.start} + {1'b0, HDR};
  assign id_p1   = {1'b0, cell_id} + 1'b1;
  assign idx_p1  = {1'b0, ctl.idx} + 1'b1;

  always_comb begin
    if (ctl.free_mode) begin
      hit = ent_r.valid && (off_sum[OFFSET_BITS-1:0] == ctl.off);
    end else begin
      hit = ent_r.valid && !ent_r.used && (ent_r.pay >= ctl.size);
    end
  end

  assign sel       = hit && !found_in;
  assign found_out = found_in || hit;

  always_comb begin
    rep = '0;
    if (sel) begin
      rep.sel       = 1'b1;
      rep.idx       = cell_id;
      rep.used      = ent_r.used;
      rep.prev_free = left.valid && !left.used;
      rep.next_free = right.valid && !right.used;
      rep.start     = ent_r.start;
      rep.pay       = ent_r.pay;
    end
  end

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctl.op)
      OP_CLEAR: begin
        ent_nxt.valid = (cell_id == '0) && (ctl.heap >= HDR);
        ent_nxt.used  = 1'b0;
        ent_nxt.start = '0;
        ent_nxt.pay   = ctl.heap - HDR;
      end
      OP_SET: begin
        if (cell_id == ctl.idx) ent_nxt.used = ctl.used_val;
      end
      OP_INSERT: begin
        if (cell_id == ctl.idx) begin
          ent_nxt.pay  = ctl.size;
          ent_nxt.used = 1'b1;
        end else if ({1'b0, cell_id} == idx_p1) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.used  = 1'b0;
          ent_nxt.start = ctl.new_start;
          ent_nxt.pay   = ctl.new_pay;
        end else if ({1'b0, cell_id} > idx_p1) begin
          ent_nxt = left;
        end
      end
      OP_REMOVE: begin
        if (id_p1 == {1'b0, ctl.idx}) begin
          ent_nxt.pay = ent_r.pay + HDR + right.pay;
        end else if (cell_id >= ctl.idx) begin
          ent_nxt = right;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= (cell_id == '0);
      ent_r.used  <= 1'b0;
      ent_r.start <= '0;
      ent_r.pay   <= HEAP_RESET - HDR;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;
endmodule
`default_nettype wire

[bench/first_fit_block_allocator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit block allocator testbench
// Runs allocate and free commands through the allocator under random input
// gaps and output stalls. An in-bench model of the block table predicts every
// result, and a checker compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
  import ffa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 12;

  // Offsets and sizes are kept one bit wider than the ports, so that a request
  // plus a header never wraps in the fit test.
  typedef logic [OFFSET_BITS:0] wide_t;

  typedef struct {
    logic [OFFSET_BITS-1:0] offset;
    logic [1:0]             status;
  } alloc_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [OFFSET_BITS-1:0] cfg_wr_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_command;
  logic [OFFSET_BITS-1:0] in_request_size;
  logic [OFFSET_BITS-1:0] in_payload_offset;
  logic                   out_valid;
  logic                   out_ready;
  logic [OFFSET_BITS-1:0] out_result_offset;
  logic [1:0]             out_status;

  first_fit_block_allocator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_request_size   (in_request_size),
    .in_payload_offset (in_payload_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_offset (out_result_offset),
    .out_status        (out_status)
  );

  // The shadow block table. It follows the block one transfer at a time.
  wide_t tbl_start [MAX_BLOCKS];
  wide_t tbl_pay   [MAX_BLOCKS];
  bit    tbl_used  [MAX_BLOCKS];
  int    tbl_count;

  alloc_result_t          expected_results[$];
  logic [OFFSET_BITS-1:0] live_offsets[$];
  logic [OFFSET_BITS-1:0] freed_offsets[$];

  int  error_count;
  int  cycle_count;
  int  burst_left;
  int  hold_cycles;
  bit  hold_request;
  int  ready_mode;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Rebuilding the table mirrors a heap size write: one free block, or none
  // when the heap cannot hold even a header.
  function automatic void rebuild_table(logic [OFFSET_BITS-1:0] heap);
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      tbl_start[k] = '0;
      tbl_pay[k] = '0;
      tbl_used[k] = 1'b0;
    end
    if (heap < HDR) begin
      tbl_count = 0;
    end else begin
      tbl_count = 1;
      tbl_pay[0] = heap - HDR;
    end
    live_offsets.delete();
    freed_offsets.delete();
  endfunction

  function automatic void drop_entry(int k);
    for (int j = k; j + 1 < tbl_count; j++) begin
      tbl_start[j] = tbl_start[j + 1];
      tbl_pay[j] = tbl_pay[j + 1];
      tbl_used[j] = tbl_used[j + 1];
    end
    tbl_count--;
  endfunction

  // First fit: the lowest free block whose payload holds the request. It is
  // split when the rest can carry a header of its own and the table has room.
  function automatic alloc_result_t first_fit(logic [OFFSET_BITS-1:0] size);
    alloc_result_t res;
    wide_t         want;
    want = wide_t'(size);
    res.offset = '0;
    res.status = ST_NOFIT;
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_used[i] && tbl_pay[i] >= want) begin
        if (tbl_pay[i] > want + HEADER_BYTES && tbl_count < MAX_BLOCKS) begin
          for (int j = tbl_count; j > i + 1; j--) begin
            tbl_start[j] = tbl_start[j - 1];
            tbl_pay[j] = tbl_pay[j - 1];
            tbl_used[j] = tbl_used[j - 1];
          end
          tbl_start[i + 1] = tbl_start[i] + HEADER_BYTES + want;
          tbl_pay[i + 1] = tbl_pay[i] - want - HEADER_BYTES;
          tbl_used[i + 1] = 1'b0;
          tbl_pay[i] = want;
          tbl_count++;
        end
        tbl_used[i] = 1'b1;
        res.offset = OFFSET_BITS'(tbl_start[i] + HEADER_BYTES);
        res.status = ST_DONE;
        live_offsets.push_back(res.offset);
        break;
      end
    end
    return res;
  endfunction

  // Release marks the block free and folds it into free neighbors.
  function automatic logic [1:0] release_block(logic [OFFSET_BITS-1:0] offset);
    int hit;
    hit = -1;
    if (offset == '0) return ST_NULL;
    for (int i = 0; i < tbl_count; i++) begin
      if (OFFSET_BITS'(tbl_start[i] + HEADER_BYTES) == offset) begin
        hit = i;
        break;
      end
    end
    if (hit < 0 || !tbl_used[hit]) return ST_UNKN;
    tbl_used[hit] = 1'b0;
    if (hit + 1 < tbl_count && !tbl_used[hit + 1]) begin
      tbl_pay[hit] = tbl_pay[hit] + HEADER_BYTES + tbl_pay[hit + 1];
      drop_entry(hit + 1);
    end
    if (hit > 0 && !tbl_used[hit - 1]) begin
      tbl_pay[hit - 1] = tbl_pay[hit - 1] + HEADER_BYTES + tbl_pay[hit];
      drop_entry(hit);
    end
    foreach (live_offsets[k]) begin
      if (live_offsets[k] == offset) begin
        live_offsets.delete(k);
        break;
      end
    end
    freed_offsets.push_back(offset);
    if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
    return ST_DONE;
  endfunction

  // Sends one command. The sender works in bursts; a gap lowers valid first,
  // and valid is left high after a transfer so back-to-back items never drop it.
  task automatic send_cmd(logic cmd, logic [OFFSET_BITS-1:0] size,
                          logic [OFFSET_BITS-1:0] offset);
    int            gap;
    alloc_result_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_request_size <= size;
    in_payload_offset <= offset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // The transfer happened at this edge, so the table moves on now.
    if (cmd == CMD_ALLOC) begin
      res = first_fit(size);
    end else begin
      res.offset = '0;
      res.status = release_block(offset);
    end
    expected_results.push_back(res);
  endtask

  task automatic alloc_cmd(logic [OFFSET_BITS-1:0] size);
    send_cmd(CMD_ALLOC, size, OFFSET_BITS'($urandom));
  endtask

  task automatic free_cmd(logic [OFFSET_BITS-1:0] offset);
    send_cmd(CMD_FREE, OFFSET_BITS'($urandom), offset);
  endtask

  // Waits until every expected result has come back, then lets the block
  // settle before anything else touches it.
  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_heap(logic [OFFSET_BITS-1:0] heap);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= heap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rebuild_table(heap);
    @(posedge clk);
  endtask

  // Reset heap: whole-heap allocation, splits, merges both ways, the null
  // pointer, unknown offsets and a double free.
  task automatic test_reset_heap;
    alloc_cmd('0);
    alloc_cmd(OFFSET_BITS'(100));
    alloc_cmd(OFFSET_BITS'(36));
    alloc_cmd('1);
    free_cmd(OFFSET_BITS'(24));
    free_cmd(OFFSET_BITS'(48));
    free_cmd(OFFSET_BITS'(48));
    free_cmd('0);
    free_cmd(OFFSET_BITS'(12345));
    free_cmd('1);
    free_cmd(OFFSET_BITS'(172));
    alloc_cmd(OFFSET_BITS'(1048576 - 24));
    alloc_cmd(OFFSET_BITS'(1));
    free_cmd(OFFSET_BITS'(24));
  endtask

  // Heaps smaller than a header, exactly one header, zero and the maximum.
  task automatic test_tiny_heaps;
    write_heap(OFFSET_BITS'(10));
    alloc_cmd('0);
    free_cmd(OFFSET_BITS'(24));
    write_heap(OFFSET_BITS'(24));
    alloc_cmd(OFFSET_BITS'(1));
    alloc_cmd('0);
    alloc_cmd('0);
    free_cmd(OFFSET_BITS'(24));
    write_heap('0);
    alloc_cmd('0);
    write_heap('1);
    alloc_cmd('1);
    alloc_cmd(OFFSET_BITS'(24'hFFFFFF - 24));
    free_cmd(OFFSET_BITS'(24));
  endtask

  // Fills the table with zero-byte blocks; once it is full the last free
  // block is handed out whole.
  task automatic test_full_table;
    write_heap(OFFSET_BITS'(4096));
    while (tbl_count < MAX_BLOCKS) alloc_cmd('0);
    alloc_cmd(OFFSET_BITS'(10));
    alloc_cmd('0);
    free_cmd(live_offsets[5]);
    free_cmd(live_offsets[5]);
    alloc_cmd(OFFSET_BITS'(1));
  endtask

  // Mostly well-formed traffic: allocations of modest size and frees of live
  // blocks, mixed with huge requests, stray offsets, null and double frees.
  task automatic test_random_mix(int count, logic [OFFSET_BITS-1:0] heap,
                                 int max_size, bit with_hold);
    int pick;
    write_heap(heap);
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == count / 2) hold_request = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 52 || (pick < 88 && live_offsets.size() == 0)) begin
        if ($urandom_range(0, 19) == 0) alloc_cmd(OFFSET_BITS'($urandom));
        else alloc_cmd(OFFSET_BITS'($urandom_range(0, max_size)));
      end else if (pick < 88) begin
        free_cmd(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
      end else if (pick < 93) begin
        free_cmd(OFFSET_BITS'($urandom));
      end else if (pick < 97 && freed_offsets.size() != 0) begin
        free_cmd(freed_offsets[$urandom_range(0, freed_offsets.size() - 1)]);
      end else begin
        free_cmd('0);
      end
    end
  endtask

  // The receiver switches among stall patterns and, on request, holds off for a
  // long stretch so that the block fills up and stops taking input.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_cycles <= 300;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      if (cycle_count % 64 == 0) ready_mode <= $urandom_range(0, 2);
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: offset %0d status %0d",
               out_result_offset, out_status);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_result_offset !== exp_res.offset) begin
          $error("result_offset: expected %0d, actual %0d", exp_res.offset,
                 out_result_offset);
          error_count++;
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    burst_left = 0;
    hold_cycles = 0;
    hold_request = 1'b0;
    ready_mode = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_command = CMD_ALLOC;
    in_request_size = '0;
    in_payload_offset = '0;
    out_ready = 1'b0;
    rebuild_table(HEAP_RESET);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_heap();
    test_tiny_heaps();
    test_full_table();
    test_random_mix(250, OFFSET_BITS'(4096), 64, 1'b0);
    test_random_mix(250, HEAP_RESET, 4096, 1'b1);
    test_random_mix(250, '1, 200000, 1'b0);
    test_random_mix(100, OFFSET_BITS'(600), 40, 1'b0);
    drain();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
